[design/dst_pkg.sv]
// Shared types and constants for the dual stack with transfer block.
`default_nettype none

package dst_pkg;

   // Operation codes carried by a request.
   typedef enum logic [1:0] {
      OP_PUSH        = 2'd0,
      OP_POP         = 2'd1,
      OP_MAIN_TO_AUX = 2'd2,
      OP_AUX_TO_MAIN = 2'd3
   } op_type;

   // Status codes returned with every response.
   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic {
      S_IDLE   = 1'b0,
      S_FINISH = 1'b1
   } state_type;

   localparam int DataWidth  = 32;
   localparam int CountWidth = 9;

endpackage

`default_nettype wire

[design/dst_if.sv]
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface dst_req_if;
   import dst_pkg::*;

   logic                        valid;
   logic                        ready;
   op_type                      op;
   logic signed [DataWidth-1:0] value;

   modport source (output valid, op, value, input ready);
   modport sink   (input valid, op, value, output ready);
endinterface

interface dst_rsp_if;
   import dst_pkg::*;

   logic                        valid;
   logic                        ready;
   status_type                  status;
   logic [CountWidth-1:0]       main_count;
   logic [CountWidth-1:0]       aux_count;
   logic signed [DataWidth-1:0] main_top;

   modport source (output valid, status, main_count, aux_count, main_top, input ready);
   modport sink   (input valid, status, main_count, aux_count, main_top, output ready);
endinterface

`default_nettype wire

[design/dst_ram.sv]
// Simple dual port synchronous RAM with a registered read.
`default_nettype none

module dst_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[design/dual_stack_with_transfer.sv]
// Top level: two bounded LIFO stacks with push, pop and transfer between them.
//
// Usage: each request on req_ch carries an operation (push to main, pop main,
// move main top to aux, move aux top to main) and a value used by push only.
// Every request yields exactly one response on rsp_ch with a status (done,
// source empty, target full), both element counts and the main stack top
// (zero when the main stack is empty). A refused request changes nothing.
// Both channels use valid/ready; a transfer happens when both are high.
//
// Timing: a request is taken in the idle cycle, the stack memories are read
// and written in that same cycle, and the finish state captures the read data
// and loads the response register once the output register is free. The
// finish state is needed for the registered read of the stack memory that
// supplies the new top after a pop or move. A new request is taken only after
// the response of the last one is loaded.
//
// Reset empties both stacks; no memory clearing is needed. When the receiver
// stalls, the held response stays in its output register, one more request
// may be taken, and its response waits in the finish state until the output
// register frees up.
`default_nettype none

module dual_stack_with_transfer #(
   parameter int STACK_DEPTH = 256
) (
   input wire logic  clock,
   input wire logic  reset,
   dst_req_if.sink   req_ch,
   dst_rsp_if.source rsp_ch
);
   import dst_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam logic [CW-1:0] CntFull = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] CntOne  = CW'(1);
   localparam logic [CW-1:0] CntTwo  = CW'(2);

   state_type                   state_ff, state_in;
   logic [CW-1:0]               main_depth_ff, main_depth_in;
   logic [CW-1:0]               aux_depth_ff, aux_depth_in;
   logic signed [DataWidth-1:0] main_top_ff, main_top_in;
   logic signed [DataWidth-1:0] aux_top_ff, aux_top_in;
   logic                        rd_main_ff, rd_main_in;
   logic                        rd_aux_ff, rd_aux_in;
   status_type                  pend_status_ff, pend_status_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   status_type                  rsp_status_ff, rsp_status_in;
   logic [CountWidth-1:0]       rsp_main_count_ff, rsp_main_count_in;
   logic [CountWidth-1:0]       rsp_aux_count_ff, rsp_aux_count_in;
   logic signed [DataWidth-1:0] rsp_main_top_ff, rsp_main_top_in;

   logic                        main_wr_en, aux_wr_en;
   logic [AW-1:0]               main_wr_addr, aux_wr_addr;
   logic [DataWidth-1:0]        main_wr_data, aux_wr_data;
   logic                        main_rd_en, aux_rd_en;
   logic [AW-1:0]               main_rd_addr, aux_rd_addr;
   logic [DataWidth-1:0]        main_rd_data, aux_rd_data;

   logic                        req_accept;
   logic                        main_empty, main_full, aux_empty, aux_full;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign main_empty = (main_depth_ff == '0);
   assign main_full  = (main_depth_ff == CntFull);
   assign aux_empty  = (aux_depth_ff == '0);
   assign aux_full   = (aux_depth_ff == CntFull);

   // Stack memories.
   dst_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DataWidth)) u_main_ram (
      .clock   (clock),
      .wr_en   (main_wr_en),
      .wr_addr (main_wr_addr),
      .wr_data (main_wr_data),
      .rd_en   (main_rd_en),
      .rd_addr (main_rd_addr),
      .rd_data (main_rd_data)
   );

   dst_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DataWidth)) u_aux_ram (
      .clock   (clock),
      .wr_en   (aux_wr_en),
      .wr_addr (aux_wr_addr),
      .wr_data (aux_wr_data),
      .rd_en   (aux_rd_en),
      .rd_addr (aux_rd_addr),
      .rd_data (aux_rd_data)
   );

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         main_depth_ff <= '0;
         aux_depth_ff  <= '0;
         main_top_ff   <= '0;
         rd_main_ff    <= 1'b0;
         rd_aux_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         main_depth_ff <= main_depth_in;
         aux_depth_ff  <= aux_depth_in;
         main_top_ff   <= main_top_in;
         rd_main_ff    <= rd_main_in;
         rd_aux_ff     <= rd_aux_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      aux_top_ff        <= aux_top_in;
      pend_status_ff    <= pend_status_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_main_count_ff <= rsp_main_count_in;
      rsp_aux_count_ff  <= rsp_aux_count_in;
      rsp_main_top_ff   <= rsp_main_top_in;
   end

   // Next state, memory accesses and response loading.
   always_comb begin
      state_in          = state_ff;
      main_depth_in     = main_depth_ff;
      aux_depth_in      = aux_depth_ff;
      main_top_in       = main_top_ff;
      aux_top_in        = aux_top_ff;
      rd_main_in        = rd_main_ff;
      rd_aux_in         = rd_aux_ff;
      pend_status_in    = pend_status_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in     = rsp_status_ff;
      rsp_main_count_in = rsp_main_count_ff;
      rsp_aux_count_in  = rsp_aux_count_ff;
      rsp_main_top_in   = rsp_main_top_ff;

      main_wr_en   = 1'b0;
      main_wr_addr = main_depth_ff[AW-1:0];
      main_wr_data = req_ch.value;
      aux_wr_en    = 1'b0;
      aux_wr_addr  = aux_depth_ff[AW-1:0];
      aux_wr_data  = main_top_ff;
      main_rd_en   = 1'b0;
      main_rd_addr = AW'(main_depth_ff - CntTwo);
      aux_rd_en    = 1'b0;
      aux_rd_addr  = AW'(aux_depth_ff - CntTwo);

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in       = S_FINISH;
               rd_main_in     = 1'b0;
               rd_aux_in      = 1'b0;
               pend_status_in = STAT_DONE;
               unique case (req_ch.op)
                  OP_PUSH: begin
                     if (main_full) begin
                        pend_status_in = STAT_FULL;
                     end else begin
                        main_wr_en    = 1'b1;
                        main_depth_in = main_depth_ff + CntOne;
                        main_top_in   = req_ch.value;
                     end
                  end
                  OP_POP: begin
                     if (main_empty) begin
                        pend_status_in = STAT_EMPTY;
                     end else begin
                        main_depth_in = main_depth_ff - CntOne;
                        if (main_depth_ff == CntOne) begin
                           main_top_in = '0;
                        end else begin
                           main_rd_en = 1'b1;
                           rd_main_in = 1'b1;
                        end
                     end
                  end
                  OP_MAIN_TO_AUX: begin
                     if (main_empty) begin
                        pend_status_in = STAT_EMPTY;
                     end else if (aux_full) begin
                        pend_status_in = STAT_FULL;
                     end else begin
                        aux_wr_en     = 1'b1;
                        aux_wr_data   = main_top_ff;
                        aux_depth_in  = aux_depth_ff + CntOne;
                        aux_top_in    = main_top_ff;
                        main_depth_in = main_depth_ff - CntOne;
                        if (main_depth_ff == CntOne) begin
                           main_top_in = '0;
                        end else begin
                           main_rd_en = 1'b1;
                           rd_main_in = 1'b1;
                        end
                     end
                  end
                  OP_AUX_TO_MAIN: begin
                     if (aux_empty) begin
                        pend_status_in = STAT_EMPTY;
                     end else if (main_full) begin
                        pend_status_in = STAT_FULL;
                     end else begin
                        main_wr_en    = 1'b1;
                        main_wr_data  = aux_top_ff;
                        main_depth_in = main_depth_ff + CntOne;
                        main_top_in   = aux_top_ff;
                        aux_depth_in  = aux_depth_ff - CntOne;
                        if (aux_depth_ff != CntOne) begin
                           aux_rd_en = 1'b1;
                           rd_aux_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                     pend_status_in = STAT_DONE;
                  end
               endcase
            end
         end
         S_FINISH: begin
            // Capture the new tops read from memory.
            if (rd_main_ff) begin
               main_top_in = main_rd_data;
            end
            if (rd_aux_ff) begin
               aux_top_in = aux_rd_data;
            end
            // Hand the response over once the output register is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = pend_status_ff;
               rsp_main_count_in = CountWidth'(main_depth_ff);
               rsp_aux_count_in  = CountWidth'(aux_depth_ff);
               rsp_main_top_in   = rd_main_ff ? main_rd_data : main_top_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.main_count = rsp_main_count_ff;
   assign rsp_ch.aux_count  = rsp_aux_count_ff;
   assign rsp_ch.main_top   = rsp_main_top_ff;

   // Counts never exceed the stack capacity.
   assert property (@(posedge clock) disable iff (reset)
      (main_depth_ff <= CntFull) && (aux_depth_ff <= CntFull))
      else $error("stack count beyond capacity");

   // An accepted request always moves the controller to the finish state.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_FINISH))
      else $error("accepted request did not enter finish state");

   // A new response appears only after a finish cycle.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised without a finish cycle");

   // A push onto a non-full main stack grows it by one.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_ch.op == OP_PUSH) && !main_full)
         |=> (main_depth_ff == $past(main_depth_ff) + CntOne))
      else $error("push did not grow main stack");

   // The cached main top reads zero whenever the controller is idle and the main stack is empty.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && main_empty) |-> (main_top_ff == '0))
      else $error("main top not zero on empty stack");

endmodule

`default_nettype wire
